// File: rtl/cswq_pkg.sv
// ----------------------------------------------------------------------------
// cswq_pkg
// Shared types, codes and defaults for the counting semaphore wait queue.
// ----------------------------------------------------------------------------
`default_nettype none

package cswq_pkg;

    localparam int CMD_W          = 2;
    localparam int TASK_W         = 4;
    localparam int PERMITS_W      = 8;

    localparam int QUEUE_SLOTS_DEF = 16;
    localparam int PERMIT_MAX_DEF  = 255;

    typedef enum logic [CMD_W-1:0] {
        CMD_WAIT    = 2'd0,
        CMD_TRYWAIT = 2'd1,
        CMD_SIGNAL  = 2'd2
    } cmd_t;

    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
    } ring_ctl_t;

    typedef struct packed {
        logic empty;
        logic full;
    } ring_sts_t;

endpackage

`default_nettype wire

// File: rtl/cswq_ram.sv
// ----------------------------------------------------------------------------
// cswq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cswq_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: rtl/cswq_permits.sv
// ----------------------------------------------------------------------------
// cswq_permits
// Permit counter with clamped reload; saturation is left to the caller via at_max.
// ----------------------------------------------------------------------------
`default_nettype none

module cswq_permits #(
    parameter int PERMIT_MAX = 255
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               load,
    input  wire logic [cswq_pkg::PERMITS_W-1:0]     load_value,
    input  wire logic                               dec,
    input  wire logic                               inc,
    output logic      [$clog2(PERMIT_MAX+1)-1:0]    count,
    output logic      [$clog2(PERMIT_MAX+1)-1:0]    count_next,
    output logic                                    nonzero,
    output logic                                    at_max
);

    import cswq_pkg::*;

    localparam int PW = $clog2(PERMIT_MAX + 1);

    logic [PW-1:0]           count_reg;
    logic [PW+PERMITS_W-1:0] load_wide;
    logic [PW-1:0]           load_clamped;

    assign load_wide    = {{PW{1'b0}}, load_value};
    assign load_clamped = (32'(load_value) > 32'(PERMIT_MAX)) ? PW'(PERMIT_MAX)
                                                              : load_wide[PW-1:0];

    assign nonzero = (count_reg != '0);
    assign at_max  = (count_reg == PW'(PERMIT_MAX));

    always_comb
    begin
        count_next = count_reg;
        if (load)
        begin
            count_next = load_clamped;
        end
        else if (dec)
        begin
            count_next = count_reg - PW'(1);
        end
        else if (inc)
        begin
            count_next = count_reg + PW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign count = count_reg;

endmodule

`default_nettype wire

// File: rtl/cswq_ring.sv
// ----------------------------------------------------------------------------
// cswq_ring
// FIFO ring of waiting task IDs, one slot kept empty, RAM backed.
// ----------------------------------------------------------------------------
`default_nettype none

module cswq_ring #(
    parameter int QUEUE_SLOTS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire cswq_pkg::ring_ctl_t           ctl,
    input  wire logic [cswq_pkg::TASK_W-1:0]   push_id,
    output cswq_pkg::ring_sts_t                sts,
    output logic      [cswq_pkg::TASK_W-1:0]   pop_id
);

    import cswq_pkg::*;

    localparam int AW = $clog2(QUEUE_SLOTS);

    logic [AW-1:0]     head_reg, head_next, head_inc;
    logic [AW-1:0]     tail_reg, tail_next, tail_inc;
    logic              bypass_reg, bypass_next;
    logic [TASK_W-1:0] bypass_data_reg;
    logic [TASK_W-1:0] ram_rd_data;

    assign head_inc = (head_reg == AW'(QUEUE_SLOTS - 1)) ? '0 : head_reg + AW'(1);
    assign tail_inc = (tail_reg == AW'(QUEUE_SLOTS - 1)) ? '0 : tail_reg + AW'(1);

    assign sts = '{empty: (head_reg == tail_reg), full: (head_inc == tail_reg)};

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        if (ctl.clear)
        begin
            head_next = '0;
            tail_next = '0;
        end
        else
        begin
            if (ctl.push)
            begin
                head_next = head_inc;
            end
            if (ctl.pop)
            begin
                tail_next = tail_inc;
            end
        end
    end

    // RAM is read ahead at the next tail; a push into that same slot is forwarded
    assign bypass_next = ctl.push && (head_reg == tail_next);

    cswq_ram #(
        .WIDTH (TASK_W),
        .DEPTH (QUEUE_SLOTS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ctl.push),
        .wr_addr (head_reg),
        .wr_data (push_id),
        .rd_addr (tail_next),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            tail_reg   <= '0;
            bypass_reg <= 1'b0;
        end
        else
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            bypass_reg <= bypass_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bypass_data_reg <= push_id;
    end

    assign pop_id = bypass_reg ? bypass_data_reg : ram_rd_data;

endmodule

`default_nettype wire

// File: rtl/counting_semaphore_wait_queue_unit.sv
// ----------------------------------------------------------------------------
// counting_semaphore_wait_queue_unit
// Counting semaphore with a FIFO queue of waiting task IDs.
// ----------------------------------------------------------------------------
//  channel | handshake                   | payload
//  --------+-----------------------------+--------------------------------------
//  in      | in_valid / in_stall         | cmd, task_id
//  out     | out_valid / out_stall       | granted, queued, retry_full,
//          |                             | woken_valid, woken_task,
//          |                             | permits_now, saturated
//  cfg     | cfg_wr_en                   | cfg_wr_data (initial permits)
//
//  One command per cycle sustained while out_stall is low; an accepted
//  command goes from the input register into the result register and
//  transfers out from there. The input register feeds one pass of counter
//  and ring-pointer logic into the result register.
//  Reset clears the count and the ring pointers; ring contents are not
//  cleared, so there is no clearing pass. A stalled output holds the result
//  and backs up into in_stall only once the input register is also occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module counting_semaphore_wait_queue_unit #(
    parameter int QUEUE_SLOTS = cswq_pkg::QUEUE_SLOTS_DEF,
    parameter int PERMIT_MAX  = cswq_pkg::PERMIT_MAX_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,

    input  wire logic                             cfg_wr_en,
    input  wire logic [cswq_pkg::PERMITS_W-1:0]   cfg_wr_data,

    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [cswq_pkg::CMD_W-1:0]       cmd,
    input  wire logic [cswq_pkg::TASK_W-1:0]      task_id,

    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic                                  granted,
    output logic                                  queued,
    output logic                                  retry_full,
    output logic                                  woken_valid,
    output logic      [cswq_pkg::TASK_W-1:0]      woken_task,
    output logic      [cswq_pkg::PERMITS_W-1:0]   permits_now,
    output logic                                  saturated
);

    import cswq_pkg::*;

    localparam int PW = $clog2(PERMIT_MAX + 1);
    localparam logic [PERMITS_W-1:0] PMAX_LO = PERMITS_W'(PERMIT_MAX);

    // input register
    logic              s1_valid_reg, s1_valid_next;
    logic [CMD_W-1:0]  s1_cmd_reg;
    logic [TASK_W-1:0] s1_task_reg;

    // result register
    logic                 out_valid_reg, out_valid_next;
    logic                 granted_reg, queued_reg, retry_full_reg;
    logic                 woken_valid_reg, saturated_reg;
    logic [TASK_W-1:0]    woken_task_reg;
    logic [PERMITS_W-1:0] permits_now_reg;

    logic in_accept;
    logic out_free;
    logic fire;

    logic          cmd_wait, cmd_try, cmd_signal;
    logic          do_grant, do_queue, do_retry, do_pop, do_sat, do_inc;
    ring_ctl_t     ring_ctl;
    ring_sts_t     ring_sts;
    logic [TASK_W-1:0] pop_id;

    logic [PW-1:0]           count, count_next;
    logic                    count_nonzero, count_at_max;
    logic [PW+PERMITS_W-1:0] count_wide;

    assign out_free  = !out_valid_reg || !out_stall;
    assign fire      = s1_valid_reg && out_free;
    assign in_stall  = s1_valid_reg && !out_free;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        cmd_wait   = 1'b0;
        cmd_try    = 1'b0;
        cmd_signal = 1'b0;
        case (cmd_t'(s1_cmd_reg))
            CMD_WAIT:    cmd_wait   = 1'b1;
            CMD_TRYWAIT: cmd_try    = 1'b1;
            CMD_SIGNAL:  cmd_signal = 1'b1;
            default:     ;
        endcase
    end

    assign do_grant = fire && (cmd_wait || cmd_try) && count_nonzero;
    assign do_queue = fire && cmd_wait && !count_nonzero && !ring_sts.full;
    assign do_retry = fire && cmd_wait && !count_nonzero && ring_sts.full;
    assign do_pop   = fire && cmd_signal && !ring_sts.empty;
    assign do_sat   = fire && cmd_signal && count_at_max;
    assign do_inc   = fire && cmd_signal && !count_at_max;

    assign ring_ctl = '{clear: cfg_wr_en, push: do_queue, pop: do_pop};

    cswq_permits #(
        .PERMIT_MAX (PERMIT_MAX)
    ) u_permits (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (cfg_wr_en),
        .load_value (cfg_wr_data),
        .dec        (do_grant),
        .inc        (do_inc),
        .count      (count),
        .count_next (count_next),
        .nonzero    (count_nonzero),
        .at_max     (count_at_max)
    );

    cswq_ring #(
        .QUEUE_SLOTS (QUEUE_SLOTS)
    ) u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ring_ctl),
        .push_id (s1_task_reg),
        .sts     (ring_sts),
        .pop_id  (pop_id)
    );

    assign count_wide = {{PERMITS_W{1'b0}}, count_next};

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (fire)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_cmd_reg  <= cmd;
            s1_task_reg <= task_id;
        end
        if (fire)
        begin
            granted_reg     <= do_grant;
            queued_reg      <= do_queue;
            retry_full_reg  <= do_retry;
            woken_valid_reg <= do_pop;
            woken_task_reg  <= do_pop ? pop_id : '0;
            permits_now_reg <= count_wide[PERMITS_W-1:0];
            saturated_reg   <= do_sat;
        end
    end

    assign out_valid   = out_valid_reg;
    assign granted     = granted_reg;
    assign queued      = queued_reg;
    assign retry_full  = retry_full_reg;
    assign woken_valid = woken_valid_reg;
    assign woken_task  = woken_task_reg;
    assign permits_now = permits_now_reg;
    assign saturated   = saturated_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        ring_ctl.push |-> !ring_sts.full)
        else $error("ring push while full");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        ring_ctl.pop |-> !ring_sts.empty)
        else $error("ring pop while empty");

    a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($countones({granted, queued, retry_full, woken_valid}) <= 1))
        else $error("more than one outcome flag set");

    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && saturated) |-> (permits_now == PMAX_LO))
        else $error("saturated result with count off maximum");

    a_grant_drops_count: assert property (@(posedge clk) disable iff (!rst_n)
        (do_grant && !cfg_wr_en) |=> (count == $past(count) - PW'(1)))
        else $error("grant did not take a permit");

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the counting semaphore wait queue. Commands go in
// through the valid/stall channel, a local model of the permit count and the
// waiter ring predicts each result, and every result transfer is compared
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------

module testbench;

    import cswq_pkg::*;

    localparam int RING_SLOTS     = QUEUE_SLOTS_DEF;
    localparam int PERMIT_LIMIT   = PERMIT_MAX_DEF;
    localparam int RESULT_LATENCY = 4;
    localparam int STALL_LIMIT    = 4000;

    // command code with no operation behind it
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic                 granted;
        logic                 queued;
        logic                 retry_full;
        logic                 woken_valid;
        logic [TASK_W-1:0]    woken_task;
        logic [PERMITS_W-1:0] permits_now;
        logic                 saturated;
    } sem_result_t;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [PERMITS_W-1:0] cfg_wr_data = '0;
    logic                 in_valid    = 1'b0;
    logic [CMD_W-1:0]     cmd         = '0;
    logic [TASK_W-1:0]    task_id     = '0;
    logic                 out_stall   = 1'b0;

    logic                 in_stall;
    logic                 out_valid;
    logic                 granted;
    logic                 queued;
    logic                 retry_full;
    logic                 woken_valid;
    logic [TASK_W-1:0]    woken_task;
    logic [PERMITS_W-1:0] permits_now;
    logic                 saturated;

    // semaphore model state
    int                   permit_count = 0;
    int                   ring_wr      = 0;
    int                   ring_rd      = 0;
    logic [TASK_W-1:0]    waiter_ids [RING_SLOTS];

    sem_result_t          pending_results [$];
    sem_result_t          oldest;
    int                   mismatch_count    = 0;
    int                   idle_cycles       = 0;
    int                   sender_idle_pct   = 0;
    int                   receiver_idle_pct = 0;

    always #1 clk = ~clk;

    counting_semaphore_wait_queue_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .task_id     (task_id),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .granted     (granted),
        .queued      (queued),
        .retry_full  (retry_full),
        .woken_valid (woken_valid),
        .woken_task  (woken_task),
        .permits_now (permits_now),
        .saturated   (saturated)
    );

    function automatic sem_result_t apply_command(input logic [CMD_W-1:0] c,
                                                  input logic [TASK_W-1:0] id);
        sem_result_t r;
        r = '0;
        case (c)
            CMD_WAIT, CMD_TRYWAIT:
            begin
                if (permit_count > 0)
                begin
                    permit_count--;
                    r.granted = 1'b1;
                end
                else if (c == CMD_WAIT)
                begin
                    // one slot always stays free
                    if ((ring_wr + 1) % RING_SLOTS == ring_rd)
                        r.retry_full = 1'b1;
                    else
                    begin
                        waiter_ids[ring_wr] = id;
                        ring_wr = (ring_wr + 1) % RING_SLOTS;
                        r.queued = 1'b1;
                    end
                end
            end
            CMD_SIGNAL:
            begin
                if (ring_rd != ring_wr)
                begin
                    r.woken_valid = 1'b1;
                    r.woken_task  = waiter_ids[ring_rd];
                    ring_rd = (ring_rd + 1) % RING_SLOTS;
                end
                if (permit_count >= PERMIT_LIMIT)
                begin
                    permit_count = PERMIT_LIMIT;
                    r.saturated  = 1'b1;
                end
                else
                    permit_count++;
            end
            default: ;
        endcase
        r.permits_now = PERMITS_W'(permit_count);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // result side: random stall, compare each transfer with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result transfer with no command outstanding");
                    mismatch_count++;
                end
                else
                begin
                    oldest = pending_results.pop_front();
                    check_field("granted", 8'(oldest.granted), 8'(granted));
                    check_field("queued", 8'(oldest.queued), 8'(queued));
                    check_field("retry_full", 8'(oldest.retry_full), 8'(retry_full));
                    check_field("woken_valid", 8'(oldest.woken_valid), 8'(woken_valid));
                    check_field("woken_task", 8'(oldest.woken_task), 8'(woken_task));
                    check_field("permits_now", oldest.permits_now, permits_now);
                    check_field("saturated", 8'(oldest.saturated), 8'(saturated));
                end
            end
            out_stall <= ($urandom_range(99) < receiver_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // valid stays up after a transfer until the next call lowers or reuses it
    task automatic send_command(input logic [CMD_W-1:0] c, input logic [TASK_W-1:0] id);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        task_id  <= id;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(apply_command(c, id));
    endtask

    task automatic idle_until_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (RESULT_LATENCY) @(posedge clk);
    endtask

    task automatic write_initial_permits(input logic [PERMITS_W-1:0] value);
        idle_until_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        permit_count = (value > PERMIT_LIMIT) ? PERMIT_LIMIT : value;
        ring_wr      = 0;
        ring_rd      = 0;
    endtask

    task automatic test_empty_semaphore();
        write_initial_permits(8'd0);
        send_command(CMD_TRYWAIT, 4'd0);
        send_command(CMD_UNUSED, 4'd15);
        send_command(CMD_SIGNAL, 4'd0);
        send_command(CMD_TRYWAIT, 4'd5);
    endtask

    task automatic test_full_queue();
        for (int i = 0; i < RING_SLOTS - 1; i++)
            send_command(CMD_WAIT, TASK_W'(15 - i));
        send_command(CMD_WAIT, 4'd0);
        send_command(CMD_SIGNAL, 4'd3);
        send_command(CMD_WAIT, 4'd9);
    endtask

    // reload also empties the ring, so the first signal wakes nobody
    task automatic test_saturation();
        write_initial_permits(8'd255);
        send_command(CMD_SIGNAL, 4'd12);
        send_command(CMD_TRYWAIT, 4'd3);
        send_command(CMD_UNUSED, 4'd10);
    endtask

    task automatic test_random_traffic(input int n_items);
        int sent;
        int burst_len;
        int signal_pct;
        int pick;
        logic [CMD_W-1:0] c;
        sent = 0;
        while (sent < n_items)
        begin
            burst_len = $urandom_range(60, 20);
            case ($urandom_range(2))
                0:       signal_pct = 10;
                1:       signal_pct = 45;
                default: signal_pct = 80;
            endcase
            if (sent == 0 || $urandom_range(3) == 0)
            begin
                case ($urandom_range(3))
                    0:       write_initial_permits(8'd0);
                    1:       write_initial_permits(8'd255);
                    2:       write_initial_permits(PERMITS_W'($urandom_range(4, 1)));
                    default: write_initial_permits(PERMITS_W'($urandom_range(255)));
                endcase
            end
            repeat (burst_len)
            begin
                pick = $urandom_range(99);
                if (pick < 3)
                    c = CMD_UNUSED;
                else if (pick < 3 + signal_pct)
                    c = CMD_SIGNAL;
                else if ($urandom_range(3) == 0)
                    c = CMD_TRYWAIT;
                else
                    c = CMD_WAIT;
                send_command(c, TASK_W'($urandom_range(15)));
            end
            sent += burst_len;
        end
    endtask

    task automatic test_drain_pause();
        repeat (2)
        begin
            repeat (12)
                send_command(CMD_W'($urandom_range(3)), TASK_W'($urandom_range(15)));
            idle_until_drained();
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        sender_idle_pct   = 16;
        receiver_idle_pct = 87;
        test_empty_semaphore();
        test_full_queue();
        test_saturation();
        test_random_traffic(560);

        sender_idle_pct   = 87;
        receiver_idle_pct = 16;
        test_random_traffic(560);
        test_drain_pause();

        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        test_random_traffic(560);

        idle_until_drained();
        repeat (RESULT_LATENCY) @(posedge clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: files.f
rtl/cswq_pkg.sv
rtl/cswq_ram.sv
rtl/cswq_permits.sv
rtl/cswq_ring.sv
rtl/counting_semaphore_wait_queue_unit.sv
tb/sv/testbench.sv
